### hw/rtl/video_sync_timing_analyzer_core_macros.svh
// Assertion macros used by the RTL file of the sync timing analyzer core.
`ifndef VIDEO_SYNC_TIMING_ANALYZER_CORE_MACROS_SVH
`define VIDEO_SYNC_TIMING_ANALYZER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VSTA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define VSTA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/vsta_pkg.sv
package vsta_pkg;

    localparam int COUNTER_WIDTH_DEF = 32;
    localparam int TIME_SHIFT_DEF    = 3;
    localparam int LINE_SHIFT_DEF    = 10;

    localparam int LIMIT_W      = 16;
    localparam int GAP_W        = 32;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int KIND_W       = 2;
    localparam int TIME_UNITS_W = 29;
    localparam int LINE_W       = 13;
    localparam int FRAME_W      = 22;

    localparam logic [LIMIT_W-1:0] EVEN_LIMIT_RST = LIMIT_W'(16 * 25);
    localparam logic [LIMIT_W-1:0] ODD_LIMIT_RST  = LIMIT_W'(16 * 50);
    localparam logic [GAP_W-1:0]   GAP_MIN_RST    = GAP_W'(50000);

    localparam logic signed [LINE_W-1:0] LINE_MAX_COUNT = 13'sd4095;
    localparam logic signed [LINE_W-1:0] LINE_NONE      = -13'sd1;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_EVEN_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ODD_LIMIT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_MIN    = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        EV_VSYNC = 2'd0,
        EV_IRQ   = 2'd1,
        EV_FRAME = 2'd2
    } event_kind_t;

    typedef enum logic [1:0] {
        PAR_EVEN    = 2'd0,
        PAR_ODD     = 2'd1,
        PAR_UNKNOWN = 2'd2
    } parity_t;

    // Bit positions of the per-sample event mask, in emission order.
    localparam int MASK_VSYNC = 0;
    localparam int MASK_IRQ   = 1;
    localparam int MASK_FRAME = 2;
    localparam int MASK_W     = 3;

    // Payload shared by all events of one sample.
    typedef struct packed {
        logic                      is_odd;
        logic [TIME_UNITS_W-1:0]   time_units;
        logic signed [LINE_W-1:0]  line_number;
        logic [FRAME_W-1:0]        frame_lines;
    } bundle_t;

    localparam int QUEUE_DEPTH = 2;

endpackage

### hw/rtl/video_sync_timing_analyzer_core.sv
// Sync timing analyzer: takes one logic-capture sample word per cycle while not stalled (sync,
// irq and blue levels) and emits VSync field changes, irq falling edges and frame lengths. The
// up to three result words of a sample go into a two-deep queue of per-sample bundles and
// leave one per cycle while m_ready is high, so the input runs at one word per cycle as long
// as samples cause at most one result each and the output is not held, and stalls only while
// the queue is full. The configuration port is always ready.
`include "video_sync_timing_analyzer_core_macros.svh"

module video_sync_timing_analyzer_core #(
    parameter int COUNTER_WIDTH = vsta_pkg::COUNTER_WIDTH_DEF,
    parameter int TIME_SHIFT    = vsta_pkg::TIME_SHIFT_DEF,
    parameter int LINE_SHIFT    = vsta_pkg::LINE_SHIFT_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vsta_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [vsta_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_csync_level,
    input  logic                                 s_irq_level,
    input  logic                                 s_blue_level,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [vsta_pkg::KIND_W-1:0]          m_event_kind,
    output logic                                 m_odd_field,
    output logic [vsta_pkg::TIME_UNITS_W-1:0]    m_time_units,
    output logic signed [vsta_pkg::LINE_W-1:0]   m_line_number,
    output logic [vsta_pkg::FRAME_W-1:0]         m_frame_lines,
    output logic                                 m_last
);

    localparam int CW    = COUNTER_WIDTH;
    localparam int CMP_W = (CW > vsta_pkg::GAP_W) ? CW : vsta_pkg::GAP_W;
    localparam int TU_W  = vsta_pkg::TIME_UNITS_W;
    localparam int FL_W  = vsta_pkg::FRAME_W;
    localparam int MW    = vsta_pkg::MASK_W;

    // Configuration registers.
    logic [vsta_pkg::LIMIT_W-1:0] even_limit_reg;
    logic [vsta_pkg::LIMIT_W-1:0] odd_limit_reg;
    logic [vsta_pkg::GAP_W-1:0]   gap_min_reg;

    // Analyzer state. A level is unknown until its known flag is set.
    logic [CW-1:0]                     sample_count_reg;
    logic                              sync_known_reg, sync_prev_reg;
    logic                              irq_known_reg, irq_prev_reg;
    logic                              blue_known_reg, blue_prev_reg;
    logic [CW-1:0]                     sync_edge_reg;
    logic [CW-1:0]                     blue_edge_reg;
    logic [CW-1:0]                     frame_start_reg;
    vsta_pkg::parity_t                 parity_reg, parity_next;
    logic signed [vsta_pkg::LINE_W-1:0] line_count_reg, line_count_next;

    // Result queue of per-sample bundles.
    vsta_pkg::bundle_t                 bundle_reg [vsta_pkg::QUEUE_DEPTH];
    logic [MW-1:0]                     mask_reg   [vsta_pkg::QUEUE_DEPTH];
    logic                              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                        count_reg;
    logic [MW-1:0]                     done_reg;

    logic accept, push, pop;

    assign cfg_ready = 1'b1;
    assign s_ready   = (count_reg != 2'(vsta_pkg::QUEUE_DEPTH));
    assign accept    = s_valid && s_ready;

    // Event detection for the incoming sample.
    logic [CW-1:0]         since_start, high_time, blue_gap;
    logic                  sync_fall, irq_fall, blue_rise_long;
    logic                  sync_change, irq_change, blue_change;
    vsta_pkg::parity_t     field_class;
    logic                  ev_vsync, ev_frame;
    logic signed [vsta_pkg::LINE_W-1:0] line_after_sync;
    logic [CW+TU_W-1:0]    tu_wide;
    logic [CW+FL_W-1:0]    fl_wide;
    logic [MW-1:0]         new_mask;
    vsta_pkg::bundle_t     new_bundle;

    always_comb begin
        since_start = sample_count_reg - frame_start_reg;
        high_time   = sample_count_reg - sync_edge_reg;
        blue_gap    = sample_count_reg - blue_edge_reg;

        sync_change = !sync_known_reg || (sync_prev_reg != s_csync_level);
        irq_change  = !irq_known_reg  || (irq_prev_reg  != s_irq_level);
        blue_change = !blue_known_reg || (blue_prev_reg != s_blue_level);
        sync_fall   = sync_change && !s_csync_level;
        irq_fall    = irq_change && !s_irq_level;
        blue_rise_long = blue_change && s_blue_level &&
                         (CMP_W'(blue_gap) > CMP_W'(gap_min_reg));

        priority if (high_time < CW'(even_limit_reg)) begin
            field_class = vsta_pkg::PAR_EVEN;
        end else if (high_time < CW'(odd_limit_reg)) begin
            field_class = vsta_pkg::PAR_ODD;
        end else begin
            field_class = vsta_pkg::PAR_UNKNOWN;
        end

        ev_vsync    = sync_fall && (field_class != vsta_pkg::PAR_UNKNOWN) &&
                      (field_class != parity_reg);
        parity_next = ev_vsync ? field_class : parity_reg;

        line_after_sync = line_count_reg;
        if (sync_fall && (line_count_reg >= 0) && (line_count_reg < vsta_pkg::LINE_MAX_COUNT)) begin
            line_after_sync = line_count_reg + 13'sd1;
        end
        line_count_next = blue_rise_long ? '0 : line_after_sync;

        // A frame start taken at count zero still reads as no frame yet.
        ev_frame = blue_rise_long && (parity_next == vsta_pkg::PAR_ODD) &&
                   (frame_start_reg != '0);

        tu_wide = (CW+TU_W)'(since_start) >> TIME_SHIFT;
        fl_wide = (CW+FL_W)'(since_start) >> LINE_SHIFT;

        new_mask = '0;
        new_mask[vsta_pkg::MASK_VSYNC] = ev_vsync;
        new_mask[vsta_pkg::MASK_IRQ]   = irq_fall;
        new_mask[vsta_pkg::MASK_FRAME] = ev_frame;

        new_bundle.is_odd      = (field_class == vsta_pkg::PAR_ODD);
        new_bundle.time_units  = tu_wide[TU_W-1:0];
        new_bundle.line_number = line_after_sync;
        new_bundle.frame_lines = fl_wide[FL_W-1:0];
    end

    assign push = accept && (new_mask != '0);

    // Output side: walk the events of the head bundle in emission order.
    logic [MW-1:0] head_rem, head_pick, rest;
    vsta_pkg::bundle_t head;
    vsta_pkg::event_kind_t kind;

    always_comb begin
        head      = bundle_reg[rd_ptr_reg];
        head_rem  = mask_reg[rd_ptr_reg] & ~done_reg;
        head_pick = head_rem & (~head_rem + MW'(1));
        rest      = head_rem & ~head_pick;
        priority if (head_pick[vsta_pkg::MASK_VSYNC]) begin
            kind = vsta_pkg::EV_VSYNC;
        end else if (head_pick[vsta_pkg::MASK_IRQ]) begin
            kind = vsta_pkg::EV_IRQ;
        end else begin
            kind = vsta_pkg::EV_FRAME;
        end
    end

    assign m_valid       = (count_reg != 2'd0);
    assign m_event_kind  = kind;
    assign m_odd_field   = (kind == vsta_pkg::EV_VSYNC) ? head.is_odd : 1'b0;
    assign m_time_units  = head.time_units;
    assign m_line_number = (kind == vsta_pkg::EV_IRQ) ? head.line_number : '0;
    assign m_frame_lines = (kind == vsta_pkg::EV_FRAME) ? head.frame_lines : '0;
    assign m_last        = (rest == '0);
    assign pop           = m_valid && m_ready && m_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            even_limit_reg   <= vsta_pkg::EVEN_LIMIT_RST;
            odd_limit_reg    <= vsta_pkg::ODD_LIMIT_RST;
            gap_min_reg      <= vsta_pkg::GAP_MIN_RST;
            sample_count_reg <= '0;
            sync_known_reg   <= 1'b0;
            irq_known_reg    <= 1'b0;
            blue_known_reg   <= 1'b0;
            sync_edge_reg    <= '0;
            blue_edge_reg    <= '0;
            frame_start_reg  <= '0;
            parity_reg       <= vsta_pkg::PAR_UNKNOWN;
            line_count_reg   <= vsta_pkg::LINE_NONE;
            wr_ptr_reg       <= 1'b0;
            rd_ptr_reg       <= 1'b0;
            count_reg        <= 2'd0;
            done_reg         <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    vsta_pkg::REG_EVEN_LIMIT: even_limit_reg <= cfg_data[vsta_pkg::LIMIT_W-1:0];
                    vsta_pkg::REG_ODD_LIMIT:  odd_limit_reg  <= cfg_data[vsta_pkg::LIMIT_W-1:0];
                    vsta_pkg::REG_GAP_MIN:    gap_min_reg    <= cfg_data[vsta_pkg::GAP_W-1:0];
                    default: ;
                endcase
            end

            if (accept) begin
                sample_count_reg <= sample_count_reg + CW'(1);
                sync_known_reg   <= 1'b1;
                irq_known_reg    <= 1'b1;
                blue_known_reg   <= 1'b1;
                sync_prev_reg    <= s_csync_level;
                irq_prev_reg     <= s_irq_level;
                blue_prev_reg    <= s_blue_level;
                if (sync_change) begin
                    sync_edge_reg <= sample_count_reg;
                end
                if (blue_change) begin
                    blue_edge_reg <= sample_count_reg;
                end
                if (blue_rise_long && (parity_next == vsta_pkg::PAR_ODD)) begin
                    frame_start_reg <= sample_count_reg;
                end
                parity_reg     <= parity_next;
                line_count_reg <= line_count_next;
            end

            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
                done_reg   <= '0;
            end else if (m_valid && m_ready) begin
                done_reg <= done_reg | head_pick;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            bundle_reg[wr_ptr_reg] <= new_bundle;
            mask_reg[wr_ptr_reg]   <= new_mask;
        end
    end

    `VSTA_ASSERT_IMPL(a_head_not_empty, aclk, aresetn, m_valid, head_rem != '0, "queued word has no event left")
    `VSTA_ASSERT_NEXT(a_push_grows, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 2'd1, "queue count did not grow on push")
    `VSTA_ASSERT_IMPL(a_line_range, aclk, aresetn, 1'b1, (line_count_reg >= vsta_pkg::LINE_NONE) && (line_count_reg <= vsta_pkg::LINE_MAX_COUNT), "line count out of range")
    `VSTA_ASSERT_IMPL(a_frame_odd, aclk, aresetn, push && new_mask[vsta_pkg::MASK_FRAME], parity_next == vsta_pkg::PAR_ODD, "frame length outside odd field")

endmodule

### tb/sv/tb_video_sync_timing_analyzer_core.sv
module tb_video_sync_timing_analyzer_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = vsta_pkg::COUNTER_WIDTH_DEF;
    localparam int SETTLE_CYCLES = 12;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_SAMPLES = 26;
    localparam logic [1:0] LVL_UNKNOWN = 2'd2;
    localparam logic [vsta_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        vsta_pkg::event_kind_t                kind;
        logic                                 odd;
        logic [vsta_pkg::TIME_UNITS_W-1:0]    tu;
        logic signed [vsta_pkg::LINE_W-1:0]   line;
        logic [vsta_pkg::FRAME_W-1:0]         fl;
        logic                                 last;
    } sta_event_t;

    typedef struct packed {
        logic                                 is_cfg;
        logic [vsta_pkg::CFG_INDEX_W-1:0]     reg_idx;
        logic [vsta_pkg::CFG_DATA_W-1:0]      reg_val;
        logic                                 cs;
        logic                                 iq;
        logic                                 bl;
        logic [1:0]                           n_pinned;
        sta_event_t [1:0]                     pinned;
    } stim_row_t;

    logic aclk;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [vsta_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [vsta_pkg::CFG_DATA_W-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic s_csync_level;
    logic s_irq_level;
    logic s_blue_level;
    logic m_valid;
    logic m_ready;
    logic [vsta_pkg::KIND_W-1:0] m_event_kind;
    logic m_odd_field;
    logic [vsta_pkg::TIME_UNITS_W-1:0] m_time_units;
    logic signed [vsta_pkg::LINE_W-1:0] m_line_number;
    logic [vsta_pkg::FRAME_W-1:0] m_frame_lines;
    logic m_last;

    video_sync_timing_analyzer_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_csync_level (s_csync_level),
        .s_irq_level   (s_irq_level),
        .s_blue_level  (s_blue_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_odd_field   (m_odd_field),
        .m_time_units  (m_time_units),
        .m_line_number (m_line_number),
        .m_frame_lines (m_frame_lines),
        .m_last        (m_last)
    );

    // Shadow of the analyzer: configuration and timing state.
    logic [vsta_pkg::LIMIT_W-1:0] even_lim = vsta_pkg::EVEN_LIMIT_RST;
    logic [vsta_pkg::LIMIT_W-1:0] odd_lim = vsta_pkg::ODD_LIMIT_RST;
    logic [vsta_pkg::GAP_W-1:0] gap_min = vsta_pkg::GAP_MIN_RST;
    logic [CW-1:0] smp_count = '0;
    logic [1:0] sync_q = LVL_UNKNOWN;
    logic [1:0] irq_q = LVL_UNKNOWN;
    logic [1:0] blue_q = LVL_UNKNOWN;
    logic [CW-1:0] sync_edge = '0;
    logic [CW-1:0] blue_edge = '0;
    logic [CW-1:0] frame_start = '0;
    vsta_pkg::parity_t parity = vsta_pkg::PAR_UNKNOWN;
    logic signed [vsta_pkg::LINE_W-1:0] line_cnt = vsta_pkg::LINE_NONE;

    sta_event_t step_evs[$];
    sta_event_t due_events[$];
    stim_row_t dir_rows[$];
    sta_event_t head_ev;

    bit calm = 1'b0;
    int faults = 0;
    int events_checked = 0;
    int samples_sent = 0;
    int reg_writes = 0;

    // Random sample generator state.
    bit gen_sync = 1'b0;
    bit gen_blue = 1'b0;
    bit gen_irq = 1'b0;
    int sync_left = 0;
    int blue_left = 0;

    function automatic sta_event_t make_event(vsta_pkg::event_kind_t kind, logic odd,
                                              logic [CW-1:0] since,
                                              logic signed [vsta_pkg::LINE_W-1:0] line,
                                              logic with_frame);
        sta_event_t ev;
        ev.kind = kind;
        ev.odd = odd;
        ev.tu = vsta_pkg::TIME_UNITS_W'(since >> vsta_pkg::TIME_SHIFT_DEF);
        ev.line = line;
        ev.fl = with_frame ? vsta_pkg::FRAME_W'(since >> vsta_pkg::LINE_SHIFT_DEF) : '0;
        ev.last = 1'b0;
        return ev;
    endfunction

    // Works out the result words caused by one sample and advances the shadow state.
    function automatic void analyze_sample(logic cs, logic iq, logic bl);
        logic [CW-1:0] now;
        logic [CW-1:0] since;
        logic [CW-1:0] span;
        vsta_pkg::parity_t nf;
        now = smp_count;
        since = now - frame_start;
        step_evs.delete();
        if ({1'b0, cs} != sync_q) begin
            sync_q = {1'b0, cs};
            if (!cs) begin
                span = now - sync_edge;
                nf = vsta_pkg::PAR_UNKNOWN;
                if (span < even_lim) begin
                    nf = vsta_pkg::PAR_EVEN;
                end else if (span < odd_lim) begin
                    nf = vsta_pkg::PAR_ODD;
                end
                if (nf != vsta_pkg::PAR_UNKNOWN && nf != parity) begin
                    parity = nf;
                    step_evs.push_back(make_event(vsta_pkg::EV_VSYNC, nf == vsta_pkg::PAR_ODD,
                                                  since, '0, 1'b0));
                end
                if (line_cnt >= 0 && line_cnt < vsta_pkg::LINE_MAX_COUNT) begin
                    line_cnt++;
                end
            end
            sync_edge = now;
        end
        if ({1'b0, iq} != irq_q) begin
            irq_q = {1'b0, iq};
            if (!iq) begin
                step_evs.push_back(make_event(vsta_pkg::EV_IRQ, 1'b0, since, line_cnt, 1'b0));
            end
        end
        if ({1'b0, bl} != blue_q) begin
            blue_q = {1'b0, bl};
            span = now - blue_edge;
            if (bl && span > gap_min) begin
                line_cnt = '0;
                if (parity == vsta_pkg::PAR_ODD) begin
                    // A frame start taken at count zero still reads as no frame yet.
                    if (frame_start != '0) begin
                        step_evs.push_back(make_event(vsta_pkg::EV_FRAME, 1'b0, since, '0,
                                                      1'b1));
                    end
                    frame_start = now;
                end
            end
            blue_edge = now;
        end
        smp_count = now + 1'b1;
        if (step_evs.size() > 0) begin
            step_evs[step_evs.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic int idle_len();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic stim_row_t smp_row(logic cs, logic iq, logic bl);
        stim_row_t r;
        r = '0;
        r.cs = cs;
        r.iq = iq;
        r.bl = bl;
        return r;
    endfunction

    function automatic stim_row_t reg_row(logic [vsta_pkg::CFG_INDEX_W-1:0] idx,
                                          logic [vsta_pkg::CFG_DATA_W-1:0] val);
        stim_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic void check_field(string fname, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            faults++;
        end
    endfunction

    // Expectations are queued before the word is offered, so the order never races the output.
    task automatic drive_sample(logic cs, logic iq, logic bl, bit use_pred);
        int n;
        analyze_sample(cs, iq, bl);
        if (use_pred) begin
            foreach (step_evs[k]) begin
                due_events.push_back(step_evs[k]);
            end
        end
        s_valid <= 1'b1;
        s_csync_level <= cs;
        s_irq_level <= iq;
        s_blue_level <= bl;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
        n = idle_len();
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Samples that cause no result may still be in flight, hence the settle time.
    task automatic drain();
        s_valid <= 1'b0;
        while (due_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [vsta_pkg::CFG_INDEX_W-1:0] idx,
                             logic [vsta_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            vsta_pkg::REG_EVEN_LIMIT: even_lim = val[vsta_pkg::LIMIT_W-1:0];
            vsta_pkg::REG_ODD_LIMIT:  odd_lim = val[vsta_pkg::LIMIT_W-1:0];
            vsta_pkg::REG_GAP_MIN:    gap_min = val;
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
    endtask

    // Mostly well-formed sync lines and blue frames, with a tenth of the words pure noise.
    task automatic random_sample();
        int hi_max;
        int lo_max;
        hi_max = (odd_lim > 20) ? 22 : int'(odd_lim) + 2;
        lo_max = (gap_min > 24) ? 28 : int'(gap_min) + 4;
        if (sync_left == 0) begin
            gen_sync = !gen_sync;
            sync_left = gen_sync ? $urandom_range(1, hi_max) : $urandom_range(1, 3);
        end
        sync_left--;
        if (blue_left == 0) begin
            gen_blue = !gen_blue;
            blue_left = gen_blue ? $urandom_range(1, 3) : $urandom_range(1, lo_max);
        end
        blue_left--;
        if ($urandom_range(0, 4) == 0) begin
            gen_irq = !gen_irq;
        end
        if ($urandom_range(0, 9) == 0) begin
            drive_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'b1);
        end else begin
            drive_sample(gen_sync, gen_irq, gen_blue, 1'b1);
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        int n;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            n = idle_len();
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_events.size() == 0) begin
                $error("result word with nothing expected: event_kind %0d", m_event_kind);
                faults++;
            end else begin
                head_ev = due_events.pop_front();
                events_checked++;
                check_field("m_event_kind", head_ev.kind, m_event_kind);
                check_field("m_odd_field", head_ev.odd, m_odd_field);
                check_field("m_time_units", head_ev.tu, m_time_units);
                check_field("m_line_number", head_ev.line, m_line_number);
                check_field("m_frame_lines", head_ev.fl, m_frame_lines);
                check_field("m_last", head_ev.last, m_last);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb_video_sync_timing_analyzer_core: errors");
        $finish;
    end

    initial begin
        stim_row_t r;
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_csync_level <= 1'b0;
        s_irq_level <= 1'b0;
        s_blue_level <= 1'b0;

        // First sample after reset: every level is an edge, so low sync and irq both fall.
        r = smp_row(1'b0, 1'b0, 1'b0);
        r.n_pinned = 2'd2;
        r.pinned[0] = '{kind: vsta_pkg::EV_VSYNC, odd: 1'b0, tu: '0, line: '0, fl: '0,
                        last: 1'b0};
        r.pinned[1] = '{kind: vsta_pkg::EV_IRQ, odd: 1'b0, tu: '0, line: vsta_pkg::LINE_NONE,
                        fl: '0, last: 1'b1};
        dir_rows.push_back(r);
        dir_rows.push_back(smp_row(1'b1, 1'b1, 1'b1));
        dir_rows.push_back(smp_row(1'b0, 1'b0, 1'b0));
        dir_rows.push_back(reg_row(vsta_pkg::REG_EVEN_LIMIT, 32'd3));
        dir_rows.push_back(reg_row(vsta_pkg::REG_ODD_LIMIT, 32'd6));
        dir_rows.push_back(reg_row(vsta_pkg::REG_GAP_MIN, 32'd4));
        dir_rows.push_back(reg_row(REG_UNUSED, 32'h5A5A_A5A5));
        // Odd pulse, then a blue start that opens the first frame without a length.
        repeat (4) dir_rows.push_back(smp_row(1'b1, 1'b0, 1'b0));
        dir_rows.push_back(smp_row(1'b0, 1'b0, 1'b0));
        dir_rows.push_back(smp_row(1'b0, 1'b0, 1'b1));
        dir_rows.push_back(smp_row(1'b1, 1'b1, 1'b1));
        dir_rows.push_back(smp_row(1'b0, 1'b0, 1'b0));
        repeat (4) dir_rows.push_back(smp_row(1'b1, 1'b1, 1'b0));
        dir_rows.push_back(smp_row(1'b0, 1'b1, 1'b0));
        dir_rows.push_back(smp_row(1'b0, 1'b0, 1'b1));
        dir_rows.push_back(smp_row(1'b1, 1'b1, 1'b1));
        // Zero limits: no pulse can be classified.
        dir_rows.push_back(reg_row(vsta_pkg::REG_EVEN_LIMIT, 32'd0));
        dir_rows.push_back(reg_row(vsta_pkg::REG_ODD_LIMIT, 32'd0));
        dir_rows.push_back(smp_row(1'b0, 1'b1, 1'b1));
        dir_rows.push_back(reg_row(vsta_pkg::REG_EVEN_LIMIT, 32'hFFFF_FFFF));
        dir_rows.push_back(reg_row(vsta_pkg::REG_ODD_LIMIT, 32'hFFFF_FFFF));
        dir_rows.push_back(reg_row(vsta_pkg::REG_GAP_MIN, 32'hFFFF_FFFF));
        dir_rows.push_back(smp_row(1'b1, 1'b1, 1'b0));
        dir_rows.push_back(smp_row(1'b0, 1'b0, 1'b1));
        // One sample that yields a field change, an irq report and a frame length.
        dir_rows.push_back(reg_row(vsta_pkg::REG_EVEN_LIMIT, 32'd1));
        dir_rows.push_back(reg_row(vsta_pkg::REG_ODD_LIMIT, 32'h0000_FFFF));
        dir_rows.push_back(reg_row(vsta_pkg::REG_GAP_MIN, 32'd0));
        dir_rows.push_back(smp_row(1'b1, 1'b1, 1'b0));
        dir_rows.push_back(smp_row(1'b0, 1'b0, 1'b1));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                drain();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                for (int k = 0; k < dir_rows[i].n_pinned; k++) begin
                    due_events.push_back(dir_rows[i].pinned[k]);
                end
                drive_sample(dir_rows[i].cs, dir_rows[i].iq, dir_rows[i].bl,
                             dir_rows[i].n_pinned == 0);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            logic [vsta_pkg::CFG_DATA_W-1:0] ev_lim;
            logic [vsta_pkg::CFG_DATA_W-1:0] od_lim;
            logic [vsta_pkg::CFG_DATA_W-1:0] gp;
            drain();
            case (p)
                1: begin
                    ev_lim = 0;
                    od_lim = $urandom_range(2, 10);
                    gp = $urandom_range(0, 6);
                end
                2: begin
                    ev_lim = 32'h0000_FFFF;
                    od_lim = 32'h0000_FFFF;
                    gp = 0;
                end
                3: begin
                    ev_lim = $urandom_range(1, 4);
                    od_lim = $urandom_range(5, 9);
                    gp = 32'hFFFF_FFFF;
                end
                default: begin
                    ev_lim = $urandom_range(1, 6);
                    od_lim = ev_lim + $urandom_range(1, 10);
                    gp = $urandom_range(0, 12);
                end
            endcase
            write_reg(vsta_pkg::REG_EVEN_LIMIT, ev_lim);
            write_reg(vsta_pkg::REG_ODD_LIMIT, od_lim);
            write_reg(vsta_pkg::REG_GAP_MIN, gp);
            calm = (p == 4);
            repeat (PHASE_SAMPLES) random_sample();
        end
        calm = 1'b0;

        drain();
        $display("%0d sample words sent, %0d result words checked, %0d register writes",
                 samples_sent, events_checked, reg_writes);
        $display("covered field changes, irq reports, frame lengths and limit extremes");
        if (faults == 0 && due_events.size() == 0) begin
            $display("tb_video_sync_timing_analyzer_core: clean");
        end else begin
            $display("tb_video_sync_timing_analyzer_core: errors");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/vsta_pkg.sv
hw/rtl/video_sync_timing_analyzer_core.sv
tb/sv/tb_video_sync_timing_analyzer_core.sv
